/* hdl/cll_pkg.sv */
// ----------------------------------------------------------------------------
// cll_pkg : shared types and constants for the configuration language lexer
// Record layout, queue bundle, lexer modes and character helpers.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int MAX_NUMBER_LEN = 32;
  localparam int MAX_IDENT_LEN  = 255;
  localparam int MAX_STRING_LEN = 1023;
  localparam int POSITION_BITS  = 16;

  localparam int LEN_BITS     = 10;
  localparam int OUT_POS_BITS = 16;
  localparam int MAX_RECORDS  = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_CONTENT  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [2:0] TYPE_LBRACE  = 3'd0;
  localparam logic [2:0] TYPE_RBRACE  = 3'd1;
  localparam logic [2:0] TYPE_SEMI    = 3'd2;
  localparam logic [2:0] TYPE_STRING  = 3'd3;
  localparam logic [2:0] TYPE_INTEGER = 3'd4;
  localparam logic [2:0] TYPE_FLOAT   = 3'd5;
  localparam logic [2:0] TYPE_IDENT   = 3'd6;

  localparam logic [1:0] ERR_ILLEGAL_CHAR = 2'd0;
  localparam logic [1:0] ERR_BAD_NUMBER   = 2'd1;
  localparam logic [1:0] ERR_BAD_HEX      = 2'd2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_ESC,
    MODE_HEX1,
    MODE_HEX2,
    MODE_HALT
  } lex_mode_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              ttype;
    logic [7:0]              cbyte;
    logic [OUT_POS_BITS-1:0] line;
    logic [OUT_POS_BITS-1:0] column;
    logic [1:0]              ecode;
  } rec_t;

  // All records caused by one item
  typedef struct packed {
    logic [1:0]                  count;
    rec_t [MAX_RECORDS-1:0]      recs;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } queue_rd_t;

  function automatic rec_t make_rec(logic [1:0] kind, logic [2:0] ttype, logic [7:0] cbyte,
                                    logic [OUT_POS_BITS-1:0] line,
                                    logic [OUT_POS_BITS-1:0] column, logic [1:0] ecode);
    rec_t r;
    r.kind   = kind;
    r.ttype  = ttype;
    r.cbyte  = cbyte;
    r.line   = line;
    r.column = column;
    r.ecode  = ecode;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [2:0] open_type(lex_mode_t md, logic is_float);
    case (md)
      MODE_IDENT:  return TYPE_IDENT;
      MODE_NUMBER: return is_float ? TYPE_FLOAT : TYPE_INTEGER;
      default:     return TYPE_STRING;
    endcase
  endfunction

endpackage

/* hdl/cll_front.sv */
// ----------------------------------------------------------------------------
// cll_front : lexer front end
// Classifies one byte per cycle while take is high, updates lexer state and
// position, and hands all records caused by the item to the queue as one bundle.
// ----------------------------------------------------------------------------
module cll_front #(
  parameter int MAX_NUMBER_LEN = cll_pkg::MAX_NUMBER_LEN,
  parameter int MAX_IDENT_LEN  = cll_pkg::MAX_IDENT_LEN,
  parameter int MAX_STRING_LEN = cll_pkg::MAX_STRING_LEN,
  parameter int POSITION_BITS  = cll_pkg::POSITION_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        in_byte,
  input  logic              end_of_input,
  output logic              push,
  output cll_pkg::bundle_t  bundle
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  function automatic logic [cll_pkg::LEN_BITS-1:0] open_limit(cll_pkg::lex_mode_t md);
    case (md)
      cll_pkg::MODE_IDENT:  return cll_pkg::LEN_BITS'(MAX_IDENT_LEN);
      cll_pkg::MODE_NUMBER: return cll_pkg::LEN_BITS'(MAX_NUMBER_LEN);
      default:              return cll_pkg::LEN_BITS'(MAX_STRING_LEN);
    endcase
  endfunction

  cll_pkg::lex_mode_t                mode, mode_next;
  logic [cll_pkg::LEN_BITS-1:0]      token_length, token_length_next;
  logic [3:0]                        hex_high, hex_high_next;
  logic                              is_float, is_float_next;
  logic [POSITION_BITS-1:0]          line_count, line_count_next;
  logic [POSITION_BITS-1:0]          column_count, column_count_next;
  logic [POSITION_BITS-1:0]          start_line, start_line_next;
  logic [POSITION_BITS-1:0]          start_column, start_column_next;

  logic [cll_pkg::OUT_POS_BITS-1:0]  ln16, cl16, sl16, sc16;
  logic [1:0]                        n;
  logic                              idle_req, pc_req, pc2_req, adv_req, closed;
  logic [7:0]                        pc_byte, pc2_byte;
  logic [2:0]                        ty;
  cll_pkg::bundle_t                  bnd;

  assign ln16 = cll_pkg::OUT_POS_BITS'(line_count);
  assign cl16 = cll_pkg::OUT_POS_BITS'(column_count);

  always_comb begin
    mode_next         = mode;
    token_length_next = token_length;
    hex_high_next     = hex_high;
    is_float_next     = is_float;
    start_line_next   = start_line;
    start_column_next = start_column;
    line_count_next   = line_count;
    column_count_next = column_count;
    sl16     = cll_pkg::OUT_POS_BITS'(start_line);
    sc16     = cll_pkg::OUT_POS_BITS'(start_column);
    n        = 2'd0;
    bnd      = '0;
    idle_req = 1'b0;
    pc_req   = 1'b0;
    pc2_req  = 1'b0;
    adv_req  = 1'b0;
    closed   = 1'b0;
    pc_byte  = in_byte;
    pc2_byte = in_byte;
    ty       = cll_pkg::TYPE_LBRACE;

    if (mode != cll_pkg::MODE_HALT) begin
      if (end_of_input) begin
        if (mode >= cll_pkg::MODE_IDENT && mode <= cll_pkg::MODE_HEX2) begin
          bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_COMPLETE,
                                          cll_pkg::open_type(mode, is_float),
                                          8'd0, sl16, sc16, cll_pkg::ERR_ILLEGAL_CHAR);
          n = n + 2'd1;
        end
        mode_next         = cll_pkg::MODE_IDLE;
        token_length_next = '0;
      end else begin
        case (mode)
          cll_pkg::MODE_COMMENT: begin
            adv_req = 1'b1;
            if (in_byte == cll_pkg::CH_LF) begin
              mode_next = cll_pkg::MODE_IDLE;
            end
          end
          cll_pkg::MODE_IDENT, cll_pkg::MODE_NUMBER: begin
            if (mode == cll_pkg::MODE_NUMBER && in_byte == cll_pkg::CH_DOT && is_float) begin
              bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_ERROR, cll_pkg::TYPE_LBRACE, 8'd0,
                                              ln16, cl16, cll_pkg::ERR_BAD_NUMBER);
              n = n + 2'd1;
              mode_next = cll_pkg::MODE_HALT;
            end else if ((mode == cll_pkg::MODE_IDENT && (cll_pkg::is_alpha(in_byte) ||
                          cll_pkg::is_digit(in_byte) || in_byte == cll_pkg::CH_UNDER)) ||
                         (mode == cll_pkg::MODE_NUMBER && (cll_pkg::is_digit(in_byte) ||
                          in_byte == cll_pkg::CH_DOT))) begin
              if (in_byte == cll_pkg::CH_DOT) begin
                is_float_next = 1'b1;
              end
              pc_req  = 1'b1;
              adv_req = 1'b1;
            end else begin
              bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_COMPLETE,
                                              cll_pkg::open_type(mode, is_float),
                                              8'd0, sl16, sc16, cll_pkg::ERR_ILLEGAL_CHAR);
              n = n + 2'd1;
              mode_next         = cll_pkg::MODE_IDLE;
              token_length_next = '0;
              idle_req          = 1'b1;
            end
          end
          cll_pkg::MODE_STRING: begin
            adv_req = 1'b1;
            if (in_byte == cll_pkg::CH_QUOTE) begin
              bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_COMPLETE, cll_pkg::TYPE_STRING,
                                              8'd0, sl16, sc16, cll_pkg::ERR_ILLEGAL_CHAR);
              n = n + 2'd1;
              mode_next         = cll_pkg::MODE_IDLE;
              token_length_next = '0;
            end else if (in_byte == cll_pkg::CH_BSLASH) begin
              mode_next = cll_pkg::MODE_ESC;
            end else begin
              pc_req = 1'b1;
            end
          end
          cll_pkg::MODE_ESC: begin
            adv_req   = 1'b1;
            mode_next = cll_pkg::MODE_STRING;
            pc_req    = 1'b1;
            case (in_byte)
              cll_pkg::CH_BSLASH: pc_byte = cll_pkg::CH_BSLASH;
              cll_pkg::CH_LOW_N:  pc_byte = cll_pkg::CH_LF;
              cll_pkg::CH_LOW_R:  pc_byte = cll_pkg::CH_CR;
              cll_pkg::CH_LOW_T:  pc_byte = cll_pkg::CH_TAB;
              cll_pkg::CH_LOW_A:  pc_byte = cll_pkg::CH_BEL;
              cll_pkg::CH_LOW_X: begin
                pc_req    = 1'b0;
                mode_next = cll_pkg::MODE_HEX1;
              end
              default: begin
                // unknown escape keeps the backslash and the character
                pc_byte = cll_pkg::CH_BSLASH;
                pc2_req = 1'b1;
              end
            endcase
          end
          cll_pkg::MODE_HEX1, cll_pkg::MODE_HEX2: begin
            if (!cll_pkg::is_hex(in_byte)) begin
              bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_ERROR, cll_pkg::TYPE_LBRACE, 8'd0,
                                              ln16, cl16, cll_pkg::ERR_BAD_HEX);
              n = n + 2'd1;
              mode_next = cll_pkg::MODE_HALT;
            end else begin
              adv_req = 1'b1;
              if (mode == cll_pkg::MODE_HEX1) begin
                hex_high_next = cll_pkg::hex_nibble(in_byte);
                mode_next     = cll_pkg::MODE_HEX2;
              end else begin
                mode_next = cll_pkg::MODE_STRING;
                pc_req    = 1'b1;
                pc_byte   = {hex_high, cll_pkg::hex_nibble(in_byte)};
              end
            end
          end
          default: begin
            mode_next = cll_pkg::MODE_IDLE;
            idle_req  = 1'b1;
          end
        endcase

        if (idle_req) begin
          if (in_byte == cll_pkg::CH_HASH) begin
            adv_req   = 1'b1;
            mode_next = cll_pkg::MODE_COMMENT;
          end else if (in_byte == cll_pkg::CH_LBRACE || in_byte == cll_pkg::CH_RBRACE ||
                       in_byte == cll_pkg::CH_SEMI) begin
            ty = (in_byte == cll_pkg::CH_LBRACE) ? cll_pkg::TYPE_LBRACE :
                 (in_byte == cll_pkg::CH_RBRACE) ? cll_pkg::TYPE_RBRACE : cll_pkg::TYPE_SEMI;
            if (n != 2'd3) begin
              bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_COMPLETE, ty, 8'd0, ln16, cl16,
                                              cll_pkg::ERR_ILLEGAL_CHAR);
              n = n + 2'd1;
            end
            adv_req = 1'b1;
          end else if (in_byte == cll_pkg::CH_QUOTE || cll_pkg::is_alpha(in_byte) ||
                       in_byte == cll_pkg::CH_UNDER || cll_pkg::is_digit(in_byte)) begin
            mode_next = (in_byte == cll_pkg::CH_QUOTE) ? cll_pkg::MODE_STRING :
                        cll_pkg::is_digit(in_byte) ? cll_pkg::MODE_NUMBER : cll_pkg::MODE_IDENT;
            token_length_next = '0;
            is_float_next     = 1'b0;
            start_line_next   = line_count;
            start_column_next = column_count;
            sl16    = ln16;
            sc16    = cl16;
            pc_req  = (in_byte != cll_pkg::CH_QUOTE);
            adv_req = 1'b1;
          end else if (cll_pkg::is_space(in_byte)) begin
            adv_req = 1'b1;
          end else if (n != 2'd3) begin
            bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_ERROR, cll_pkg::TYPE_LBRACE, 8'd0,
                                            ln16, cl16, cll_pkg::ERR_ILLEGAL_CHAR);
            n = n + 2'd1;
            mode_next = cll_pkg::MODE_HALT;
          end
        end

        if (pc_req && n != 2'd3) begin
          bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_CONTENT,
                                          cll_pkg::open_type(mode_next, is_float_next),
                                          pc_byte, sl16, sc16, cll_pkg::ERR_ILLEGAL_CHAR);
          n = n + 2'd1;
          token_length_next = token_length_next + 1'b1;
          if (token_length_next >= open_limit(mode_next) && n != 2'd3) begin
            bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_COMPLETE,
                                            cll_pkg::open_type(mode_next, is_float_next),
                                            8'd0, sl16, sc16, cll_pkg::ERR_ILLEGAL_CHAR);
            n = n + 2'd1;
            mode_next         = cll_pkg::MODE_IDLE;
            token_length_next = '0;
            closed            = 1'b1;
          end
        end

        if (pc2_req && !closed && n != 2'd3) begin
          bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_CONTENT, cll_pkg::TYPE_STRING,
                                          pc2_byte, sl16, sc16, cll_pkg::ERR_ILLEGAL_CHAR);
          n = n + 2'd1;
          token_length_next = token_length_next + 1'b1;
          if (token_length_next >= open_limit(mode_next) && n != 2'd3) begin
            bnd.recs[n] = cll_pkg::make_rec(cll_pkg::KIND_COMPLETE, cll_pkg::TYPE_STRING,
                                            8'd0, sl16, sc16, cll_pkg::ERR_ILLEGAL_CHAR);
            n = n + 2'd1;
            mode_next         = cll_pkg::MODE_IDLE;
            token_length_next = '0;
          end
        end

        // position moves after all records that use the current position
        if (adv_req) begin
          if (in_byte == cll_pkg::CH_LF) begin
            if (line_count != POS_MAX) begin
              line_count_next = line_count + 1'b1;
            end
            column_count_next = '0;
          end else if (column_count != POS_MAX) begin
            column_count_next = column_count + 1'b1;
          end
        end
      end
    end
    bnd.count = n;
  end

  assign push   = take && (n != 2'd0);
  assign bundle = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= cll_pkg::MODE_IDLE;
      token_length <= '0;
      hex_high     <= '0;
      is_float     <= 1'b0;
      line_count   <= '0;
      column_count <= '0;
      start_line   <= '0;
      start_column <= '0;
    end else if (take) begin
      mode         <= mode_next;
      token_length <= token_length_next;
      hex_high     <= hex_high_next;
      is_float     <= is_float_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
    end
  end

endmodule

/* hdl/cll_queue.sv */
// ----------------------------------------------------------------------------
// cll_queue : record bundle queue
// Small FIFO of per-item bundles between the lexer front and the back end.
// ----------------------------------------------------------------------------
module cll_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cll_pkg::bundle_t    push_data,
  output logic                full,
  input  logic                pop,
  output cll_pkg::queue_rd_t  rd
);

  cll_pkg::bundle_t                   mem [cll_pkg::QUEUE_DEPTH];
  logic [cll_pkg::PTR_BITS-1:0]       wr_ptr, rd_ptr;
  logic [cll_pkg::CNT_BITS-1:0]       count;

  assign full      = (count == cll_pkg::CNT_BITS'(cll_pkg::QUEUE_DEPTH));
  assign rd.valid  = (count != '0);
  assign rd.bundle = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + cll_pkg::CNT_BITS'(push) - cll_pkg::CNT_BITS'(pop);
    end
  end

endmodule

/* hdl/cll_back.sv */
// ----------------------------------------------------------------------------
// cll_back : record serialiser
// Walks the head bundle, one record per unstalled cycle, into the output register.
// ----------------------------------------------------------------------------
module cll_back (
  input  logic                clk,
  input  logic                rst,
  input  cll_pkg::queue_rd_t  rd,
  output logic                pop,
  output logic                record_valid,
  input  logic                record_stall,
  output logic [1:0]          record_kind,
  output logic [2:0]          token_type,
  output logic [7:0]          content_byte,
  output logic [15:0]         token_line,
  output logic [15:0]         token_column,
  output logic [1:0]          error_code,
  output logic                last_of_run
);

  logic [1:0]    idx;
  logic          load, last;
  cll_pkg::rec_t r;

  assign load = !record_valid || !record_stall;
  assign r    = rd.bundle.recs[idx];
  assign last = (idx == rd.bundle.count - 2'd1);
  assign pop  = load && rd.valid && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      record_valid <= rd.valid;
      if (rd.valid) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && rd.valid) begin
      record_kind  <= r.kind;
      token_type   <= r.ttype;
      content_byte <= r.cbyte;
      token_line   <= r.line;
      token_column <= r.column;
      error_code   <= r.ecode;
      last_of_run  <= last;
    end
  end

endmodule

/* hdl/config_language_lexer_unit.sv */
// An item's records pass through the bundle queue, then the output register.
// Throughput: one byte per cycle while each byte gives at most one record and
// record_stall is low; a byte giving more records holds the output while they
// drain; a 4-item bundle queue between lexer and output absorbs such bursts.
// Reset: synchronous; clears lexer mode, position counters, queue and output
// valid. After an error record the lexer halts until reset.
// ----------------------------------------------------------------------------
// config_language_lexer_unit : streaming lexer for a configuration language
// Front end lexes bytes into record bundles, back end streams the records.
// ----------------------------------------------------------------------------
module config_language_lexer_unit #(
  parameter int MAX_NUMBER_LEN = cll_pkg::MAX_NUMBER_LEN,
  parameter int MAX_IDENT_LEN  = cll_pkg::MAX_IDENT_LEN,
  parameter int MAX_STRING_LEN = cll_pkg::MAX_STRING_LEN,
  parameter int POSITION_BITS  = cll_pkg::POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        record_valid,
  input  logic        record_stall,
  output logic [1:0]  record_kind,
  output logic [2:0]  token_type,
  output logic [7:0]  content_byte,
  output logic [15:0] token_line,
  output logic [15:0] token_column,
  output logic [1:0]  error_code,
  output logic        last_of_run
);

  logic               take, push, full, pop;
  cll_pkg::bundle_t   bundle;
  cll_pkg::queue_rd_t rd;

  assign byte_stall = full;
  assign take       = byte_valid && !full;

  cll_front #(
    .MAX_NUMBER_LEN (MAX_NUMBER_LEN),
    .MAX_IDENT_LEN  (MAX_IDENT_LEN),
    .MAX_STRING_LEN (MAX_STRING_LEN),
    .POSITION_BITS  (POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .push         (push),
    .bundle       (bundle)
  );

  cll_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .full      (full),
    .pop       (pop),
    .rd        (rd)
  );

  cll_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rd           (rd),
    .pop          (pop),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record_kind  (record_kind),
    .token_type   (token_type),
    .content_byte (content_byte),
    .token_line   (token_line),
    .token_column (token_column),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

endmodule

/* hdl/cll_checker.sv */
// ----------------------------------------------------------------------------
// cll_checker : port-level checks for the lexer
// Watches the record channel for ordering and halt behaviour.
// ----------------------------------------------------------------------------
module cll_checker (
  input logic        clk,
  input logic        rst,
  input logic        record_valid,
  input logic        record_stall,
  input logic [1:0]  record_kind,
  input logic [2:0]  token_type,
  input logic [7:0]  content_byte,
  input logic [15:0] token_line,
  input logic [15:0] token_column,
  input logic [1:0]  error_code,
  input logic        last_of_run
);

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_stall |=> record_valid && $stable(record_kind) &&
    $stable(content_byte) && $stable(token_line) && $stable(token_column))
    else $error("record changed while stalled");

  // an error always closes the run of its item
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_kind == cll_pkg::KIND_ERROR |-> last_of_run)
    else $error("error record not last of run");

  // no record follows straight after an accepted error
  a_halt: assert property (@(posedge clk) disable iff (rst)
    record_valid && !record_stall && record_kind == cll_pkg::KIND_ERROR |=> !record_valid)
    else $error("record after error");

  a_content: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_kind == cll_pkg::KIND_CONTENT |->
    error_code == cll_pkg::ERR_ILLEGAL_CHAR &&
    (token_type == cll_pkg::TYPE_STRING || token_type == cll_pkg::TYPE_INTEGER ||
     token_type == cll_pkg::TYPE_FLOAT || token_type == cll_pkg::TYPE_IDENT))
    else $error("content record with bad type or error code");

endmodule

bind config_language_lexer_unit cll_checker u_cll_checker (.*);
